// ===== hdl/idst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idst_pkg
// Types and codes shared by the ID stack front end, back end and top level.
// ----------------------------------------------------------------------------
package idst_pkg;

  localparam logic [1:0] FUNC_PUSH   = 2'd0;
  localparam logic [1:0] FUNC_SEARCH = 2'd1;
  localparam logic [1:0] FUNC_POP    = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam logic signed [31:0] RESET_LOW  = -32'sd100;
  localparam logic signed [31:0] RESET_HIGH = 32'sd100;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_SEARCH,
    OP_POP,
    OP_NOP
  } op_e;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] sample_id;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic [5:0]         location;
    logic signed [31:0] popped_id;
    logic [6:0]         count;
    logic signed [31:0] min_id;
    logic signed [31:0] max_id;
  } out_beat_t;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] id;
  } item_t;

endpackage

// ===== hdl/idst_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idst_front
// Accepts input beats, decodes the function code and buffers the decoded
// items in a two-entry queue towards the back end.
// ----------------------------------------------------------------------------
module idst_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  idst_pkg::in_beat_t in_data_i,
  output logic               item_valid_o,
  input  logic               item_pop_i,
  output idst_pkg::item_t    item_o
);

  idst_pkg::item_t q_mem [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      fill_q, fill_d;
  logic            push;
  idst_pkg::item_t dec;

  always_comb begin
    dec.id = in_data_i.sample_id;
    case (in_data_i.func)
      idst_pkg::FUNC_PUSH:   dec.op = idst_pkg::OP_PUSH;
      idst_pkg::FUNC_SEARCH: dec.op = idst_pkg::OP_SEARCH;
      idst_pkg::FUNC_POP:    dec.op = idst_pkg::OP_POP;
      default:               dec.op = idst_pkg::OP_NOP;
    endcase
  end

  assign in_ready_o   = (fill_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (fill_q != 2'd0);
  assign item_o       = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = item_pop_i ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !item_pop_i) begin
      fill_d = fill_q + 2'd1;
    end else if (!push && item_pop_i) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

// ===== hdl/idst_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idst_back
// Executes push, pop and search on the ID store, tracks count, min and max,
// and holds each result in an output register.
// ----------------------------------------------------------------------------
module idst_back #(
  parameter int STORE_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  output logic                item_pop_o,
  input  idst_pkg::item_t     item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output idst_pkg::out_beat_t out_data_o
);

  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int IW = $clog2(STORE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_SRCH = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic signed [31:0]  min_q, min_d;
  logic signed [31:0]  max_q, max_d;
  logic signed [31:0]  id_q, id_d;
  logic [IW-1:0]       addr_q, addr_d;
  logic [IW-1:0]       dist_q, dist_d;
  logic                out_valid_q, out_valid_d;
  idst_pkg::out_beat_t out_q;
  idst_pkg::out_beat_t resp;
  logic                load;
  logic                take;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  logic [IW-1:0]       rd_addr;
  logic [31:0]         mem [STORE_DEPTH];
  logic [31:0]         rdata_q;

  assign take       = (state_q == S_IDLE) && item_valid_i && (!out_valid_q || out_ready_i);
  assign item_pop_o = take;

  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    min_d          = min_q;
    max_d          = max_q;
    id_d           = id_q;
    addr_d         = addr_q;
    dist_d         = dist_q;
    load           = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = IW'(count_q);
    rd_addr        = IW'(count_q - CW'(1));
    resp           = '0;
    resp.status    = idst_pkg::STATUS_OK;
    case (state_q)
      S_IDLE: begin
        if (take) begin
          case (item_i.op)
            idst_pkg::OP_PUSH: begin
              load = 1'b1;
              if (count_q == CW'(STORE_DEPTH)) begin
                resp.status = idst_pkg::STATUS_FULL;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + CW'(1);
                if (count_q == '0 || item_i.id < min_q) min_d = item_i.id;
                if (count_q == '0 || item_i.id > max_q) max_d = item_i.id;
              end
            end
            idst_pkg::OP_SEARCH: begin
              if (count_q == '0) begin
                load = 1'b1;
              end else begin
                id_d    = item_i.id;
                addr_d  = IW'(count_q - CW'(1));
                dist_d  = '0;
                state_d = S_SRCH;
              end
            end
            idst_pkg::OP_POP: begin
              if (count_q == '0) begin
                load        = 1'b1;
                resp.status = idst_pkg::STATUS_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
                state_d = S_POP;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        load           = 1'b1;
        resp.popped_id = rdata_q;
        state_d        = S_IDLE;
      end
      S_SRCH: begin
        rd_addr = addr_q - IW'(1);
        if (rdata_q == id_q) begin
          load          = 1'b1;
          resp.found    = 1'b1;
          resp.location = 6'(dist_q);
          state_d       = S_IDLE;
        end else if (addr_q == '0) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end else begin
          addr_d = addr_q - IW'(1);
          dist_d = dist_q + IW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    resp.count  = 7'(count_d);
    resp.min_id = min_d;
    resp.max_id = max_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= item_i.id;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    addr_q <= addr_d;
    dist_q <= dist_d;
    if (load) begin
      out_q <= resp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      min_q       <= idst_pkg::RESET_LOW;
      max_q       <= idst_pkg::RESET_HIGH;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      min_q       <= min_d;
      max_q       <= max_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/id_stack_with_search_minmax_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_stack_with_search_minmax_top
// LIFO store of signed IDs with linear search and running min/max.
// ----------------------------------------------------------------------------
// Push, no-op and refused ops answer without a store read; pop reads the top
// entry first. Search scans from the top down and reports the distance of a match;
// the store is scanned one entry per cycle through its single read port.
// Throughput: one beat per cycle into a two-entry queue while it is not full; execution is serial.
// Reset: asynchronous; count 0, min -100, max 100. Store contents are not
// cleared and the block is ready straight after reset.
// ----------------------------------------------------------------------------
module id_stack_with_search_minmax_top #(
  parameter int STORE_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  idst_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output idst_pkg::out_beat_t out_data_o
);

  logic            item_valid;
  logic            item_pop;
  idst_pkg::item_t item;

  idst_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop),
    .item_o       (item)
  );

  idst_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .item_i       (item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule
